// ===== rtl/bqlp_pkg.sv =====
// Shared constants and types of the biquad low-pass filter with warm-up.
// Depends on nothing; the interfaces and the top level follow it.
package bqlp_pkg;

   // Coefficient and warm-up counter widths
   localparam int COEF_W = 18;
   localparam int CNT_W  = 16;

   // APB-style register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   typedef logic [REG_IDX_W-1:0]      reg_idx_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic [CNT_W-1:0]          cnt_type;

   // Register indexes, byte address 4*index
   localparam reg_idx_type REG_FF_COEF_0    = 3'd0;
   localparam reg_idx_type REG_FF_COEF_1    = 3'd1;
   localparam reg_idx_type REG_FF_COEF_2    = 3'd2;
   localparam reg_idx_type REG_FB_COEF_1    = 3'd3;
   localparam reg_idx_type REG_FB_COEF_2    = 3'd4;
   localparam reg_idx_type REG_WARMUP_COUNT = 3'd5;

   // Reset values
   localparam coef_type FF_COEF_0_RESET    = 18'sd32768;
   localparam cnt_type  WARMUP_COUNT_RESET = 16'd500;

endpackage

// ===== rtl/bqlp_req_if.sv =====
// Sample input channel of the biquad low-pass filter: valid/ready and one sample.
// Depends on nothing.
interface bqlp_req_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/bqlp_rsp_if.sv =====
// Result channel of the biquad low-pass filter: valid/ready, sample and flags.
// Depends on nothing.
interface bqlp_rsp_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_out;
   logic                         in_warmup;
   logic                         saturated;

   modport source (output valid, output sample_out, output in_warmup, output saturated,
                   input ready);
   modport sink   (input valid, input sample_out, input in_warmup, input saturated,
                   output ready);
endinterface

// ===== rtl/biquad_lowpass_with_warmup.sv =====
// Top level of the biquad low-pass filter (direct form 1) with warm-up pass-through.
// Depends on bqlp_pkg, bqlp_req_if and bqlp_rsp_if.
//
//   channel   | kind         | carries
//   ----------+--------------+-----------------------------------------------
//   req_ch    | valid/ready  | sample_in (signed, DATA_WIDTH)
//   rsp_ch    | valid/ready  | sample_out (signed), in_warmup, saturated
//   psel ...  | APB write/rd | ff_coef_0..2, fb_coef_1..2, warmup_count
//
// Cycles: one sample per clock sustained while rsp_ch.ready is high; a result passes
// the input register, then the result register, before it is offered. The five
// products and their sum with the rounding and clipping sit between those two
// registers, and the filter history is updated in the same edge that loads the
// result register.
// Reset: synchronous, active high; clears history, warm-up counter and valid flags,
// and loads the coefficient defaults (unity gain, 500 warm-up samples).
// Stalls: the result register holds while rsp_ch.ready is low; the input register
// keeps taking samples as long as it can hand on to the result register.
module biquad_lowpass_with_warmup #(
   parameter int DATA_WIDTH     = 16,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   bqlp_req_if.sink                           req_ch,
   bqlp_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bqlp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bqlp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bqlp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   // Product of a coefficient and a sample, and the sum of five of them
   localparam int PROD_W = DATA_WIDTH + bqlp_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + 3;

   localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]      ROUND_HALF =
      ACC_W'(1) << (COEF_FRAC_BITS - 1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   bqlp_pkg::coef_type ff_coef_0_ff, ff_coef_1_ff, ff_coef_2_ff;
   bqlp_pkg::coef_type fb_coef_1_ff, fb_coef_2_ff;
   bqlp_pkg::cnt_type  warmup_count_ff;

   logic                  csr_write;
   bqlp_pkg::reg_idx_type csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   // Word addressing: drop the byte offset
   assign csr_idx   = paddr[bqlp_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_coef_0_ff    <= bqlp_pkg::FF_COEF_0_RESET;
         ff_coef_1_ff    <= '0;
         ff_coef_2_ff    <= '0;
         fb_coef_1_ff    <= '0;
         fb_coef_2_ff    <= '0;
         warmup_count_ff <= bqlp_pkg::WARMUP_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            bqlp_pkg::REG_FF_COEF_0:    ff_coef_0_ff <= pwdata[bqlp_pkg::COEF_W-1:0];
            bqlp_pkg::REG_FF_COEF_1:    ff_coef_1_ff <= pwdata[bqlp_pkg::COEF_W-1:0];
            bqlp_pkg::REG_FF_COEF_2:    ff_coef_2_ff <= pwdata[bqlp_pkg::COEF_W-1:0];
            bqlp_pkg::REG_FB_COEF_1:    fb_coef_1_ff <= pwdata[bqlp_pkg::COEF_W-1:0];
            bqlp_pkg::REG_FB_COEF_2:    fb_coef_2_ff <= pwdata[bqlp_pkg::COEF_W-1:0];
            bqlp_pkg::REG_WARMUP_COUNT: warmup_count_ff <= pwdata[bqlp_pkg::CNT_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Read back: coefficients sign-extended, counter limit zero-extended
   always_comb begin
      unique case (csr_idx)
         bqlp_pkg::REG_FF_COEF_0:    prdata = bqlp_pkg::CSR_DATA_W'(ff_coef_0_ff);
         bqlp_pkg::REG_FF_COEF_1:    prdata = bqlp_pkg::CSR_DATA_W'(ff_coef_1_ff);
         bqlp_pkg::REG_FF_COEF_2:    prdata = bqlp_pkg::CSR_DATA_W'(ff_coef_2_ff);
         bqlp_pkg::REG_FB_COEF_1:    prdata = bqlp_pkg::CSR_DATA_W'(fb_coef_1_ff);
         bqlp_pkg::REG_FB_COEF_2:    prdata = bqlp_pkg::CSR_DATA_W'(fb_coef_2_ff);
         bqlp_pkg::REG_WARMUP_COUNT: prdata = bqlp_pkg::CSR_DATA_W'(warmup_count_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Handshake: input register feeding the result register
   // ---------------------------------------------------------------------------
   logic                         in_valid_ff;
   logic signed [DATA_WIDTH-1:0] in_sample_ff;
   logic                         rsp_valid_ff;
   logic                         out_free;   // result register can load this cycle
   logic                         advance;    // input register hands on its sample
   logic                         req_xfer;

   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign advance      = in_valid_ff & out_free;
   assign req_ch.ready = ~in_valid_ff | out_free;
   assign req_xfer     = req_ch.valid & req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sample_ff <= req_ch.sample_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Filter datapath
   // ---------------------------------------------------------------------------
   logic signed [DATA_WIDTH-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   bqlp_pkg::cnt_type            warmup_counter_ff;

   logic signed [PROD_W-1:0]     prod_x0, prod_x1, prod_x2, prod_y1, prod_y2;
   logic signed [ACC_W-1:0]      acc_sum, acc_rnd, acc_shift;
   logic                         clip_hi, clip_lo;
   logic                         warming;
   logic signed [DATA_WIDTH-1:0] filt_sample, y_in;
   logic                         sat_in;

   assign warming = warmup_counter_ff < warmup_count_ff;

   // Five independent products, all sized to the full product width
   assign prod_x0 = PROD_W'(ff_coef_0_ff) * PROD_W'(in_sample_ff);
   assign prod_x1 = PROD_W'(ff_coef_1_ff) * PROD_W'(x1_ff);
   assign prod_x2 = PROD_W'(ff_coef_2_ff) * PROD_W'(x2_ff);
   assign prod_y1 = PROD_W'(fb_coef_1_ff) * PROD_W'(y1_ff);
   assign prod_y2 = PROD_W'(fb_coef_2_ff) * PROD_W'(y2_ff);

   // Three guard bits keep the five-term sum and the rounding offset exact
   assign acc_sum = ACC_W'(prod_x0) + ACC_W'(prod_x1) + ACC_W'(prod_x2)
                  - ACC_W'(prod_y1) - ACC_W'(prod_y2);
   // Round half up: add one half, then floor by the arithmetic shift
   assign acc_rnd   = acc_sum + ROUND_HALF;
   assign acc_shift = acc_rnd >>> COEF_FRAC_BITS;

   // Clip when the bits above the sample's sign bit are not all sign copies
   assign clip_hi = ~acc_shift[ACC_W-1] &  (|acc_shift[ACC_W-2:DATA_WIDTH-1]);
   assign clip_lo =  acc_shift[ACC_W-1] & ~(&acc_shift[ACC_W-2:DATA_WIDTH-1]);

   always_comb begin
      priority if (clip_hi) begin
         filt_sample = SAMPLE_MAX;
      end else if (clip_lo) begin
         filt_sample = SAMPLE_MIN;
      end else begin
         filt_sample = acc_shift[DATA_WIDTH-1:0];
      end
   end

   // During warm-up pass the sample straight through and never flag clipping
   assign y_in   = warming ? in_sample_ff : filt_sample;
   assign sat_in = ~warming & (clip_hi | clip_lo);

   // History advances with each sample that reaches the result register, the counter only during warm-up
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff             <= '0;
         x2_ff             <= '0;
         y1_ff             <= '0;
         y2_ff             <= '0;
         warmup_counter_ff <= '0;
      end else if (advance) begin
         x1_ff <= in_sample_ff;
         x2_ff <= x1_ff;
         y1_ff <= y_in;
         y2_ff <= y1_ff;
         if (warming) begin
            warmup_counter_ff <= warmup_counter_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------
   logic signed [DATA_WIDTH-1:0] sample_out_ff;
   logic                         in_warmup_ff;
   logic                         saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_out_ff <= y_in;
         in_warmup_ff  <= warming;
         saturated_ff  <= sat_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = sample_out_ff;
   assign rsp_ch.in_warmup  = in_warmup_ff;
   assign rsp_ch.saturated  = saturated_ff;

endmodule
